/* rtl/core/qpch_pkg.sv */
// Package for the quadrilateral point/circle hit test core.
// Holds widths, register indexes and default parameters; no dependencies.
package qpch_pkg;
  localparam int unsigned CoordW      = 16;
  localparam int unsigned RadiusW     = 15;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned FracBitsDef = 4;
  localparam int unsigned GateRangeDef = 100;
  localparam int unsigned NumRegs     = 8;

  localparam logic [CfgIdxW-1:0] RegAx = 3'd0;
  localparam logic [CfgIdxW-1:0] RegAy = 3'd1;
  localparam logic [CfgIdxW-1:0] RegBx = 3'd2;
  localparam logic [CfgIdxW-1:0] RegBy = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCx = 3'd4;
  localparam logic [CfgIdxW-1:0] RegCy = 3'd5;
  localparam logic [CfgIdxW-1:0] RegDx = 3'd6;
  localparam logic [CfgIdxW-1:0] RegDy = 3'd7;

  localparam logic ActPoint  = 1'b0;
  localparam logic ActCircle = 1'b1;
endpackage

/* rtl/core/quad_point_circle_hit_test_core.sv */
// Top level of the quadrilateral point/circle hit test core.
// Depends on qpch_pkg.
//
// Usage:
//  - Query channel: a transaction is accepted at a rising edge with start high
//    and busy low. busy is always low, so one query can enter every cycle.
//  - Result: hit_o is valid for one cycle while done_o is high; done_o follows
//    each accepted query through the vld_q shift register, in query order.
//    The receiver cannot stall.
//  - Config channel: cfg_valid_i/cfg_ready_o (ready always high) with a 4-bit
//    register index and 16-bit data; indexes beyond 7 are dropped. Write only
//    while no query is in flight.
//  - Throughput is one query per cycle; the pipeline stages are difference /
//    product / min-max / partial square / sum / compare.
//  - Reset clears all vertex registers to zero and empties the pipeline.
module quad_point_circle_hit_test_core #(
  parameter int unsigned FracBits  = qpch_pkg::FracBitsDef,
  parameter int unsigned GateRange = qpch_pkg::GateRangeDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                action_i,
  input  logic signed [qpch_pkg::CoordW-1:0]  point_x_i,
  input  logic signed [qpch_pkg::CoordW-1:0]  point_y_i,
  input  logic [qpch_pkg::RadiusW-1:0]        radius_i,
  input  logic signed [qpch_pkg::CoordW-1:0]  gate_center_x_i,
  input  logic signed [qpch_pkg::CoordW-1:0]  gate_center_y_i,
  output logic                                done_o,
  output logic                                hit_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [3:0]                          cfg_index_i,
  input  logic [qpch_pkg::CoordW-1:0]         cfg_data_i
);
  import qpch_pkg::*;

  localparam int unsigned RangeW = 32;
  localparam logic [RangeW-1:0] RangeFix = RangeW'(GateRange) << FracBits;
  localparam logic [63:0] RangeSq = 64'(RangeFix) * 64'(RangeFix);

  logic signed [CoordW-1:0] vx_q [4];
  logic signed [CoordW-1:0] vy_q [4];

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        vx_q[i] <= '0;
        vy_q[i] <= '0;
      end
    end else if (cfg_valid_i && !cfg_index_i[3]) begin
      if (!cfg_index_i[0]) vx_q[cfg_index_i[2:1]] <= cfg_data_i;
      else                 vy_q[cfg_index_i[2:1]] <= cfg_data_i;
    end
  end

  // ---------------- stage 1: differences ----------------
  logic [5:0] vld_q;
  logic       act1_q;
  logic signed [17:0] gx1_q, gy1_q;
  logic signed [17:0] dxp_q [4];   // px - x_i
  logic signed [17:0] dyp_q [4];   // py - y_i
  logic signed [17:0] ex_q [4];    // x_{i+1} - x_i
  logic signed [17:0] ey_q [4];
  logic [RadiusW-1:0] r1_q;
  logic lt_q [4];                  // py < y_i

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else         vld_q <= {vld_q[4:0], start};
  end

  always_ff @(posedge clk_i) begin
    act1_q <= action_i;
    r1_q   <= radius_i;
    gx1_q  <= 18'(point_x_i) - 18'(gate_center_x_i);
    gy1_q  <= 18'(point_y_i) - 18'(gate_center_y_i);
    for (int i = 0; i < 4; i++) begin
      dxp_q[i] <= 18'(point_x_i) - 18'(vx_q[i]);
      dyp_q[i] <= 18'(point_y_i) - 18'(vy_q[i]);
      ex_q[i]  <= 18'(vx_q[(i+1)%4]) - 18'(vx_q[i]);
      ey_q[i]  <= 18'(vy_q[(i+1)%4]) - 18'(vy_q[i]);
      lt_q[i]  <= point_y_i < vy_q[i];
    end
  end

  // ---------------- stage 2: products ----------------
  // Projections taken relative to the point: q_k = (v_k - p).n ; gap if
  // -max(q) - r|n| > 0 or min(q) - r|n| > 0.
  logic act2_q;
  logic [36:0] dist2_q;
  logic signed [36:0] lhs_q [4], rhs_q [4];
  logic strad_q [4], dypos_q [4];
  logic signed [36:0] q_q [3][4];
  logic [36:0] nn_q [3];
  logic [29:0] rr_q;

  always_ff @(posedge clk_i) begin
    act2_q  <= act1_q;
    dist2_q <= 37'(36'(gx1_q * gx1_q)) + 37'(36'(gy1_q * gy1_q));
    rr_q    <= 30'(r1_q) * 30'(r1_q);
    for (int i = 0; i < 4; i++) begin
      lhs_q[i]   <= 37'(dxp_q[i] * ey_q[i]);
      rhs_q[i]   <= 37'(dyp_q[i] * ex_q[i]);
      strad_q[i] <= lt_q[i] != lt_q[(i+1)%4];
      dypos_q[i] <= ey_q[i] > 0;
    end
    for (int e = 0; e < 3; e++) begin
      nn_q[e] <= 37'(36'(ey_q[e] * ey_q[e])) + 37'(36'(ex_q[e] * ex_q[e]));
      for (int k = 0; k < 4; k++) begin
        // n = (-ey, ex); (v-p).n = -(v-p).x*ey + (v-p).y*ex
        q_q[e][k] <= 37'(dxp_q[k] * ey_q[e]) - 37'(dyp_q[k] * ex_q[e]);
      end
    end
  end

  // ---------------- stage 3: crossing parity, min/max ----------------
  logic act3_q, gate3_q, inside3_q;
  logic signed [37:0] dh_q [3], dl_q [3];
  logic [36:0] nn3_q [3];
  logic [29:0] rr3_q;
  logic [3:0] cr;
  logic signed [36:0] mx [3], mn [3];

  always_comb begin
    for (int i = 0; i < 4; i++)
      cr[i] = strad_q[i] && (dypos_q[i] ? (lhs_q[i] < rhs_q[i]) : (lhs_q[i] > rhs_q[i]));
    for (int e = 0; e < 3; e++) begin
      mx[e] = q_q[e][0];
      mn[e] = q_q[e][0];
      for (int k = 1; k < 4; k++) begin
        if (q_q[e][k] > mx[e]) mx[e] = q_q[e][k];
        if (q_q[e][k] < mn[e]) mn[e] = q_q[e][k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act3_q    <= act2_q;
    gate3_q   <= 64'(dist2_q) <= RangeSq;
    inside3_q <= ^cr;
    rr3_q     <= rr_q;
    for (int e = 0; e < 3; e++) begin
      dh_q[e]  <= -38'(mx[e]);
      dl_q[e]  <= 38'(mn[e]);
      nn3_q[e] <= nn_q[e];
    end
  end

  // ---------------- stage 4: partial squares ----------------
  // A positive test value is below 2^33, split into 16 high and 17 low bits.
  logic act4_q, gate4_q, inside4_q;
  logic pos4_q [6];
  logic signed [37:0] dsel [6];
  logic [31:0] phh_q [6];
  logic [32:0] phl_q [6];
  logic [33:0] pll_q [6];
  logic [45:0] prh_q [3];
  logic [46:0] prl_q [3];

  always_comb begin
    for (int e = 0; e < 3; e++) begin
      dsel[2*e]   = dh_q[e];
      dsel[2*e+1] = dl_q[e];
    end
  end

  always_ff @(posedge clk_i) begin
    act4_q    <= act3_q;
    gate4_q   <= gate3_q;
    inside4_q <= inside3_q;
    for (int j = 0; j < 6; j++) begin
      pos4_q[j] <= dsel[j] > 0;
      phh_q[j]  <= 32'(dsel[j][32:17]) * 32'(dsel[j][32:17]);
      phl_q[j]  <= 33'(dsel[j][32:17]) * 33'(dsel[j][16:0]);
      pll_q[j]  <= 34'(dsel[j][16:0]) * 34'(dsel[j][16:0]);
    end
    for (int e = 0; e < 3; e++) begin
      prh_q[e] <= 46'(rr3_q) * 46'(nn3_q[e][32:17]);
      prl_q[e] <= 47'(rr3_q) * 47'(nn3_q[e][16:0]);
    end
  end

  // ---------------- stage 5: sums ----------------
  logic act5_q, gate5_q, inside5_q;
  logic pos5_q [6];
  logic [65:0] dsq_q [6];
  logic [63:0] rn_q [3];

  always_ff @(posedge clk_i) begin
    act5_q    <= act4_q;
    gate5_q   <= gate4_q;
    inside5_q <= inside4_q;
    for (int j = 0; j < 6; j++) begin
      pos5_q[j] <= pos4_q[j];
      dsq_q[j]  <= (66'(phh_q[j]) << 34) + (66'(phl_q[j]) << 18) + 66'(pll_q[j]);
    end
    for (int e = 0; e < 3; e++)
      rn_q[e] <= (64'(prh_q[e]) << 17) + 64'(prl_q[e]);
  end

  // ---------------- stage 6: compare and output ----------------
  logic hit_q, gap;
  always_comb begin
    gap = 1'b0;
    for (int j = 0; j < 6; j++)
      if (pos5_q[j] && dsq_q[j] > 66'(rn_q[j/2])) gap = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    hit_q <= gate5_q && ((act5_q == ActPoint) ? inside5_q : !gap);
  end

  assign done_o = vld_q[5];
  assign hit_o  = hit_q;
endmodule

/* rtl/core/qpch_checker.sv */
// Port-level checker for the hit test core, bound to the top level.
// Depends on quad_point_circle_hit_test_core.
module qpch_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input logic cfg_ready_o
);
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##6 done_o) else $error("missing result");
  a_nospur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 6)) else $error("spurious result");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("core busy");
  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("cfg stalled");
endmodule

bind quad_point_circle_hit_test_core qpch_checker u_qpch_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .done_o(done_o),
  .cfg_ready_o(cfg_ready_o)
);
